// ===== rtl/core/dts_pkg.sv =====
package dts_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = 4;
	localparam int MASK_W     = 16;
	localparam int COUNT_W    = 5;

	localparam logic [COUNT_W-1:0] MAX_ACTIVE_RST = COUNT_W'(2);

	typedef enum logic [1:0] {
		ST_EMPTY     = 2'd0,
		ST_WAITING   = 2'd1,
		ST_RUNNING   = 2'd2,
		ST_COMPLETED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_SCAN   = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_ADDED     = 3'd1,
		EV_STARTED   = 3'd2,
		EV_COMPLETED = 3'd3,
		EV_REMOVED   = 3'd4,
		EV_REJECTED  = 3'd5
	} event_t;

endpackage

// ===== rtl/core/dependency_task_scheduler.sv =====
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+------------------------------------
// command   | in        | start & !busy                 | command, slot, dep_mask
// result    | out       | result_valid, one cycle       | event_res, event_slot, running_count
// config    | in        | cfg_valid & cfg_ready         | cfg_data (max_active)
//
// one command per cycle; busy is never raised
// path: command register, then one pass of table logic into the result register,
// so result_valid rises in the cycle after the command register fills and is taken at the next edge
// the slot table and counters are plain flops updated in that one pass
// reset clears status, done flags, counters and pointer at once; no clearing pass
// the receiver cannot stall: every result is shown for exactly one cycle
module dependency_task_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [dts_pkg::SLOT_W-1:0]  slot,
	input  logic [dts_pkg::MASK_W-1:0]  dep_mask,
	output logic                        result_valid,
	output logic [2:0]                  event_res,
	output logic [dts_pkg::SLOT_W-1:0]  event_slot,
	output logic [dts_pkg::COUNT_W-1:0] running_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dts_pkg::COUNT_W-1:0] cfg_data
);
	import dts_pkg::*;

	// command register
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [MASK_W-1:0]  mask_s1;

	// slot table
	status_t            status_q [SLOTS];
	logic [SLOTS-1:0]   done_q;
	logic [MASK_W-1:0]  deps_q [SLOTS];
	logic [COUNT_W-1:0] act_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic [COUNT_W-1:0] max_active_q;

	// result register
	logic               res_valid_q;
	event_t             ev_q;
	logic [SLOT_W-1:0]  ev_slot_q;
	logic [COUNT_W-1:0] count_q;

	// next-state values
	status_t            status_d [SLOTS];
	logic [SLOTS-1:0]   done_d;
	logic [COUNT_W-1:0] act_d;
	logic [SLOT_W-1:0]  ptr_d;
	event_t             ev_d;
	logic [SLOT_W-1:0]  ev_slot_d;
	logic               dep_wr;
	logic               dep_zero;
	logic               dep_col_clr;
	logic               slot_ok;
	logic [SLOTS-1:0]   running_vec;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// slot numbers beyond the table are rejected
	assign slot_ok = (int'(slot_s1) < SLOTS);

	always_comb begin
		status_d    = status_q;
		done_d      = done_q;
		act_d       = act_q;
		ptr_d       = ptr_q;
		ev_d        = EV_REJECTED;
		ev_slot_d   = slot_s1;
		dep_wr      = 1'b0;
		dep_zero    = 1'b0;
		dep_col_clr = 1'b0;
		unique case (cmd_s1)
			CMD_ADD: begin
				if (slot_ok && status_q[slot_s1] == ST_EMPTY) begin
					status_d[slot_s1] = ST_WAITING;
					done_d[slot_s1]   = 1'b0;
					dep_wr            = 1'b1;
					ev_d              = EV_ADDED;
				end
			end
			CMD_FINISH: begin
				// repeated finish reports just set the flag again
				if (slot_ok && status_q[slot_s1] == ST_RUNNING) begin
					done_d[slot_s1] = 1'b1;
					ev_d            = EV_NONE;
				end
			end
			CMD_SCAN: begin
				ev_slot_d = ptr_q;
				ev_d      = EV_NONE;
				if (status_q[ptr_q] == ST_RUNNING && done_q[ptr_q]) begin
					// completion releases this slot's bit in every mask
					dep_col_clr     = 1'b1;
					status_d[ptr_q] = ST_COMPLETED;
					done_d[ptr_q]   = 1'b0;
					if (act_q != '0) begin
						act_d = act_q - COUNT_W'(1);
					end
					ev_d = EV_COMPLETED;
				end else if (status_q[ptr_q] == ST_WAITING && deps_q[ptr_q] == '0 &&
						act_q < max_active_q) begin
					status_d[ptr_q] = ST_RUNNING;
					done_d[ptr_q]   = 1'b0;
					act_d           = act_q + COUNT_W'(1);
					ev_d            = EV_STARTED;
				end
				// round-robin, empty slots included
				ptr_d = (int'(ptr_q) == SLOTS - 1) ? '0 : ptr_q + SLOT_W'(1);
			end
			CMD_REMOVE: begin
				if (slot_ok && status_q[slot_s1] == ST_COMPLETED) begin
					status_d[slot_s1] = ST_EMPTY;
					done_d[slot_s1]   = 1'b0;
					dep_zero          = 1'b1;
					ev_d              = EV_REMOVED;
				end
			end
			default: begin
			end
		endcase
	end

	// command capture, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			done_q       <= '0;
			act_q        <= '0;
			ptr_q        <= '0;
			max_active_q <= MAX_ACTIVE_RST;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= ST_EMPTY;
			end
		end else begin
			valid_s1    <= start && !busy;
			res_valid_q <= valid_s1;
			if (cfg_valid && cfg_ready) begin
				max_active_q <= cfg_data;
			end
			if (valid_s1) begin
				status_q <= status_d;
				done_q   <= done_d;
				act_q    <= act_d;
				ptr_q    <= ptr_d;
			end
		end
	end

	// payload registers and dependency masks (masks undefined until an add writes them)
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= cmd_t'(command);
			slot_s1 <= slot;
			mask_s1 <= dep_mask;
		end
		if (valid_s1) begin
			ev_q      <= ev_d;
			ev_slot_q <= ev_slot_d;
			count_q   <= act_d;
			if (dep_col_clr) begin
				for (int i = 0; i < SLOTS; i++) begin
					deps_q[i][ptr_q] <= 1'b0;
				end
			end
			if (dep_wr) begin
				deps_q[slot_s1] <= mask_s1;
			end
			if (dep_zero) begin
				deps_q[slot_s1] <= '0;
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign event_res     = ev_q;
	assign event_slot    = ev_slot_q;
	assign running_count = count_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			running_vec[i] = (status_q[i] == ST_RUNNING);
		end
	end

	// the active count tracks the number of running slots
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(running_vec) == int'(act_q))
		else $error("active count out of step with running slots");

	// a done flag only ever sits on a running slot
	a_done_on_running: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q & ~running_vec) == '0)
		else $error("done flag on a slot that is not running");

	// every captured command yields exactly one result strobe
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid)
		else $error("captured command produced no result");

	// the scan pointer moves only on a scan tick
	a_ptr_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && cmd_s1 == CMD_SCAN) |=> $stable(ptr_q))
		else $error("scan pointer moved without a scan tick");

endmodule
